// ===== hw/rtl/kot_pkg.sv =====
// Shared types, constants and keyword/operator table of the tokenizer.
`default_nettype none
package kot_pkg;

   // Line counter width and table size.
   localparam int LINE_BITS     = 24;
   localparam int TABLE_ENTRIES = 25;

   // Fixed field widths of the item channels.
   localparam int CFG_LINE_BITS = 24;
   localparam int OUT_LINE_BITS = 24;
   localparam int CLASS_BITS    = 5;
   localparam int KIND_BITS     = 2;
   localparam int RSP_DATA_BITS = 40;
   localparam int RSP_USER_BITS = 3;

   // Held characters of an alphabetic or operator run.
   localparam int PEND_DEPTH    = 6;
   localparam int PEND_IDX_BITS = $clog2(PEND_DEPTH);
   localparam int OP_RUN_MAX    = 7;
   localparam int CNT_BITS      = $clog2(OP_RUN_MAX + 1);
   localparam int IDX_BITS      = $clog2(PEND_DEPTH + 1);
   localparam int TEXT_BITS     = 8 * PEND_DEPTH;

   localparam logic [CFG_LINE_BITS-1:0] FIRST_LINE_RESET = CFG_LINE_BITS'(1);
   localparam logic [63:0] LINE_TOP64 = (64'd1 << LINE_BITS) - 64'd1;
   localparam logic [63:0] OUT_TOP64  = (64'd1 << OUT_LINE_BITS) - 64'd1;

   // Record kinds, error kinds and token classes.
   localparam logic [KIND_BITS-1:0]  REC_VALUE      = 2'd0;
   localparam logic [KIND_BITS-1:0]  REC_END        = 2'd1;
   localparam logic [KIND_BITS-1:0]  REC_ERROR      = 2'd2;
   localparam logic                  ERR_FORBIDDEN  = 1'b0;
   localparam logic                  ERR_OPERATOR   = 1'b1;
   localparam logic [CLASS_BITS-1:0] CLS_IDENT      = 5'd0;
   localparam logic [CLASS_BITS-1:0] CLS_NUMBER     = 5'd1;
   localparam logic [CLASS_BITS-1:0] CLS_STRING     = 5'd2;
   localparam logic [CLASS_BITS-1:0] CLS_TABLE_BASE = 5'd3;
   localparam logic [CLASS_BITS-1:0] CLS_LPAREN     = CLS_TABLE_BASE + 5'd2;
   localparam logic [CLASS_BITS-1:0] CLS_RPAREN     = CLS_TABLE_BASE + 5'd3;

   // Table text, first character in the top byte, padded with zeros.
   localparam logic [TEXT_BITS-1:0] TAB_TEXT [TABLE_ENTRIES] = '{
      {"extern"},         {"def", 24'd0},     {"(", 40'd0},       {")", 40'd0},
      {"+", 40'd0},       {"-", 40'd0},       {"*", 40'd0},       {"/", 40'd0},
      {"**", 32'd0},      {"+=", 32'd0},      {"-=", 32'd0},      {"*=", 32'd0},
      {"/=", 32'd0},      {"**=", 24'd0},     {"and", 24'd0},     {"or", 32'd0},
      {"xor", 24'd0},     {"not", 24'd0},     {"==", 32'd0},      {"!=", 32'd0},
      {">=", 32'd0},      {"<=", 32'd0},      {">", 40'd0},       {"<", 40'd0},
      {"=", 40'd0}
   };
   localparam logic [CNT_BITS-1:0] TAB_LEN [TABLE_ENTRIES] = '{
      3'd6, 3'd3, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
      3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1,
      3'd1
   };

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ALPHA,
      MODE_IDENT,
      MODE_NUM,
      MODE_OP,
      MODE_STR,
      MODE_COMMENT
   } mode_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_STR_STEP,
      OP_STORE,
      OP_EMIT_CHAR,
      OP_EMIT_PEND,
      OP_FLUSH_LAST,
      OP_CLOSE_HIT,
      OP_CLOSE_END,
      OP_CLOSE_ERR,
      OP_START
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type               op;
      logic [PEND_IDX_BITS-1:0] idx;
      logic                     flush_out;
      logic                     end_text;
   } cmd_type;

   typedef struct packed {
      mode_type            mode;
      logic                halt;
      logic                eot;
      logic                alnum;
      logic                num_char;
      logic                op_char;
      logic                newline;
      logic [CNT_BITS-1:0] pend_count;
      logic                hit;
      logic                emit_ok;
   } status_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]     kind;
      logic [CLASS_BITS-1:0]    cls;
      logic [7:0]               val;
      logic [OUT_LINE_BITS-1:0] line;
      logic                     ek;
   } rec_type;

   typedef struct packed {
      logic                   hit;
      logic [CLASS_BITS-1:0]  idx;
   } lookup_type;

   // Compares the held run against every table entry in parallel.
   function automatic lookup_type table_lookup(
      input logic [PEND_DEPTH-1:0][7:0] pend,
      input logic [CNT_BITS-1:0]        cnt
   );
      lookup_type r;
      logic       m;
      r = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         m = (TAB_LEN[i] == cnt);
         for (int b = 0; b < PEND_DEPTH; b++) begin
            if ((CNT_BITS'(b) < TAB_LEN[i]) &&
                (pend[b] != TAB_TEXT[i][TEXT_BITS-1-8*b -: 8])) begin
               m = 1'b0;
            end
         end
         if (m) begin
            r.hit = 1'b1;
            r.idx = CLASS_BITS'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [LINE_BITS-1:0] line_load(input logic [CFG_LINE_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      if (w > LINE_TOP64) begin
         w = LINE_TOP64;
      end
      return LINE_BITS'(w);
   endfunction

   function automatic logic [OUT_LINE_BITS-1:0] line_out(input logic [LINE_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      if (w > OUT_TOP64) begin
         w = OUT_TOP64;
      end
      return OUT_LINE_BITS'(w);
   endfunction

   function automatic logic [LINE_BITS-1:0] line_next(input logic [LINE_BITS-1:0] v);
      return (&v) ? v : v + LINE_BITS'(1);
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/keyword_operator_tokenizer_core.sv =====
// Top level of the streaming keyword and operator tokenizer.
`default_nettype none
// This block takes source text one character per input item and produces token records on the
// response stream. It counts lines, skips whitespace and '#' comments, and splits the text into
// identifiers, numbers, quoted strings, keywords, operators and parentheses. Identifier, number
// and string characters come out as value records, followed by a token-end record that carries
// the token class and the line on which the token started; keywords, operators and parentheses
// give a token-end record alone. Alphabetic runs of up to six characters are held back until
// the keyword decision is made. A forbidden character or an unknown operator run gives an
// error record, after which the block drops everything up to the item that carries tlast.
// The item with tlast set closes any open token after its own character is handled. The final
// record of each input item carries rsp_tlast. The controller handles one input item at a time
// and the datapath produces at most one record per cycle. A character that extends or starts
// a token is accepted and then scanned; a character that ends a token adds a close phase and a
// phase that starts the next token, and each held character that must be flushed as an
// identifier adds an emit step. The last record of an item waits in the hold stage until
// the item is done and leaves in the first waiting cycle in which the output register is free;
// the next item is accepted no earlier than that cycle, and the block stalls while a record
// waits in the hold stage and the response stream is not taking records. The first_line value
// is written through csr_wen/csr_wdata straight into the line counter; the line counter is
// not reloaded at the end of the text. There is no clearing pass after reset.
module keyword_operator_tokenizer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input item: tdata[7:0] text_byte; tlast is end_of_text.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,
   input  wire logic                              req_tlast,
   // Result item: tdata[4:0] token_class, [12:5] value_byte, [36:13] token_line,
   // [39:37] zero; tlast is last_of_run.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [kot_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   // Result tuser: [1:0] record_kind, [2] error_kind.
   output logic [kot_pkg::RSP_USER_BITS-1:0]      rsp_tuser,
   output logic                                   rsp_tlast,
   // Configuration: first_line.
   input  wire logic                              csr_wen,
   input  wire logic [kot_pkg::CFG_LINE_BITS-1:0] csr_wdata
);

   // Commands from the controller and status back from the datapath.
   kot_pkg::cmd_type    cmd;
   kot_pkg::status_type status;

   kot_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kot_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/kot_datapath.sv =====
// Tokenizer datapath: scan state, held characters, line counter and record output.
`default_nettype none
module kot_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire kot_pkg::cmd_type                      cmd,
   output kot_pkg::status_type                        status,
   input  wire logic [7:0]                            req_tdata,
   input  wire logic                                  req_tlast,
   input  wire logic                                  csr_wen,
   input  wire logic [kot_pkg::CFG_LINE_BITS-1:0]     csr_wdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [kot_pkg::RSP_DATA_BITS-1:0]          rsp_tdata,
   output logic [kot_pkg::RSP_USER_BITS-1:0]          rsp_tuser,
   output logic                                       rsp_tlast
);

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam int PAD_BITS = kot_pkg::RSP_DATA_BITS - kot_pkg::CLASS_BITS - 8
                             - kot_pkg::OUT_LINE_BITS;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_opch(input logic [7:0] c);
      return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
             (c == "!") || (c == ">") || (c == "<") || (c == "=");
   endfunction

   function automatic kot_pkg::rec_type make_rec(
      input logic [kot_pkg::KIND_BITS-1:0]     kind,
      input logic [kot_pkg::CLASS_BITS-1:0]    cls,
      input logic [7:0]                        val,
      input logic [kot_pkg::OUT_LINE_BITS-1:0] line,
      input logic                              ek
   );
      kot_pkg::rec_type r;
      r.kind = kind;
      r.cls  = cls;
      r.val  = val;
      r.line = line;
      r.ek   = ek;
      return r;
   endfunction

   logic [7:0]                              char_ff, char_in;
   logic                                    eot_ff, eot_in;
   kot_pkg::mode_type                       mode_ff, mode_in;
   logic [kot_pkg::PEND_DEPTH-1:0][7:0]     pend_ff, pend_in;
   logic [kot_pkg::CNT_BITS-1:0]            pcnt_ff, pcnt_in;
   logic [kot_pkg::LINE_BITS-1:0]           line_ff, line_in;
   logic [kot_pkg::LINE_BITS-1:0]           start_ff, start_in;
   logic                                    halt_ff, halt_in;
   kot_pkg::rec_type                        hold_ff, hold_in;
   logic                                    hold_v_ff, hold_v_in;
   kot_pkg::rec_type                        out_ff, out_in;
   logic                                    out_last_ff, out_last_in;
   logic                                    out_v_ff, out_v_in;

   logic                                    gen;
   kot_pkg::rec_type                        gen_rec;
   kot_pkg::lookup_type                     look;
   logic                                    out_free;
   logic [kot_pkg::OUT_LINE_BITS-1:0]       start_out, line_now;
   logic [kot_pkg::CLASS_BITS-1:0]          run_cls;

   assign look      = kot_pkg::table_lookup(pend_ff, pcnt_ff);
   assign out_free  = !out_v_ff || rsp_tready;
   assign start_out = kot_pkg::line_out(start_ff);
   assign line_now  = kot_pkg::line_out(line_ff);

   always_comb begin
      case (mode_ff)
         kot_pkg::MODE_NUM: run_cls = kot_pkg::CLS_NUMBER;
         kot_pkg::MODE_STR: run_cls = kot_pkg::CLS_STRING;
         default:           run_cls = kot_pkg::CLS_IDENT;
      endcase
   end

   always_comb begin
      status.mode       = mode_ff;
      status.halt       = halt_ff;
      status.eot        = eot_ff;
      status.alnum      = is_alpha(char_ff) || is_digit(char_ff);
      status.num_char   = is_digit(char_ff) || (char_ff == CH_DOT);
      status.op_char    = is_opch(char_ff);
      status.newline    = (char_ff == CH_NL);
      status.pend_count = pcnt_ff;
      status.hit        = look.hit;
      status.emit_ok    = !hold_v_ff || out_free;
   end

   always_comb begin
      char_in  = char_ff;
      eot_in   = eot_ff;
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      pcnt_in  = pcnt_ff;
      line_in  = line_ff;
      start_in = start_ff;
      halt_in  = halt_ff;
      gen      = 1'b0;
      gen_rec  = make_rec(kot_pkg::REC_VALUE, kot_pkg::CLS_IDENT, 8'd0, start_out,
                          kot_pkg::ERR_FORBIDDEN);

      case (cmd.op)
         kot_pkg::OP_LATCH: begin
            char_in = req_tdata;
            eot_in  = req_tlast;
         end
         kot_pkg::OP_STR_STEP: begin
            gen = 1'b1;
            if ((char_ff == CH_QUOTE) || (char_ff == CH_NUL)) begin
               gen_rec = make_rec(kot_pkg::REC_END, kot_pkg::CLS_STRING, 8'd0, start_out,
                                  kot_pkg::ERR_FORBIDDEN);
               mode_in = kot_pkg::MODE_IDLE;
            end else begin
               gen_rec = make_rec(kot_pkg::REC_VALUE, kot_pkg::CLS_STRING, char_ff,
                                  start_out, kot_pkg::ERR_FORBIDDEN);
               if (char_ff == CH_NL) begin
                  line_in = kot_pkg::line_next(line_ff);
               end
            end
         end
         kot_pkg::OP_STORE: begin
            if (pcnt_ff < kot_pkg::CNT_BITS'(kot_pkg::PEND_DEPTH)) begin
               pend_in[pcnt_ff[kot_pkg::PEND_IDX_BITS-1:0]] = char_ff;
            end
            if (pcnt_ff < kot_pkg::CNT_BITS'(kot_pkg::OP_RUN_MAX)) begin
               pcnt_in = pcnt_ff + kot_pkg::CNT_BITS'(1);
            end
         end
         kot_pkg::OP_EMIT_CHAR: begin
            gen     = 1'b1;
            gen_rec = make_rec(kot_pkg::REC_VALUE, run_cls, char_ff, start_out,
                               kot_pkg::ERR_FORBIDDEN);
         end
         kot_pkg::OP_EMIT_PEND: begin
            gen     = 1'b1;
            gen_rec = make_rec(kot_pkg::REC_VALUE, kot_pkg::CLS_IDENT, pend_ff[cmd.idx],
                               start_out, kot_pkg::ERR_FORBIDDEN);
         end
         kot_pkg::OP_FLUSH_LAST: begin
            gen     = 1'b1;
            gen_rec = make_rec(kot_pkg::REC_VALUE, kot_pkg::CLS_IDENT, char_ff, start_out,
                               kot_pkg::ERR_FORBIDDEN);
            mode_in = kot_pkg::MODE_IDENT;
            pcnt_in = '0;
         end
         kot_pkg::OP_CLOSE_HIT: begin
            gen     = 1'b1;
            gen_rec = make_rec(kot_pkg::REC_END, look.idx + kot_pkg::CLS_TABLE_BASE, 8'd0,
                               start_out, kot_pkg::ERR_FORBIDDEN);
            mode_in = kot_pkg::MODE_IDLE;
            pcnt_in = '0;
         end
         kot_pkg::OP_CLOSE_END: begin
            gen     = 1'b1;
            gen_rec = make_rec(kot_pkg::REC_END, run_cls, 8'd0, start_out,
                               kot_pkg::ERR_FORBIDDEN);
            mode_in = kot_pkg::MODE_IDLE;
            pcnt_in = '0;
         end
         kot_pkg::OP_CLOSE_ERR: begin
            gen     = 1'b1;
            gen_rec = make_rec(kot_pkg::REC_ERROR, kot_pkg::CLS_IDENT, 8'd0, start_out,
                               kot_pkg::ERR_OPERATOR);
            halt_in = 1'b1;
            mode_in = kot_pkg::MODE_IDLE;
            pcnt_in = '0;
         end
         kot_pkg::OP_START: begin
            mode_in = kot_pkg::MODE_IDLE;
            if (is_space(char_ff)) begin
               if (char_ff == CH_NL) begin
                  line_in = kot_pkg::line_next(line_ff);
               end
            end else if (is_alpha(char_ff) || is_opch(char_ff)) begin
               start_in   = line_ff;
               pend_in[0] = char_ff;
               pcnt_in    = kot_pkg::CNT_BITS'(1);
               mode_in    = is_alpha(char_ff) ? kot_pkg::MODE_ALPHA : kot_pkg::MODE_OP;
            end else if (is_digit(char_ff) || (char_ff == CH_DOT)) begin
               start_in = line_ff;
               gen      = 1'b1;
               gen_rec  = make_rec(kot_pkg::REC_VALUE, kot_pkg::CLS_NUMBER, char_ff,
                                   line_now, kot_pkg::ERR_FORBIDDEN);
               mode_in  = kot_pkg::MODE_NUM;
            end else if (char_ff == CH_QUOTE) begin
               start_in = line_ff;
               mode_in  = kot_pkg::MODE_STR;
            end else if (char_ff == CH_HASH) begin
               mode_in = kot_pkg::MODE_COMMENT;
            end else if ((char_ff == CH_LPAR) || (char_ff == CH_RPAR)) begin
               gen     = 1'b1;
               gen_rec = make_rec(kot_pkg::REC_END,
                                  (char_ff == CH_LPAR) ? kot_pkg::CLS_LPAREN
                                                       : kot_pkg::CLS_RPAREN,
                                  8'd0, line_now, kot_pkg::ERR_FORBIDDEN);
            end else begin
               gen     = 1'b1;
               gen_rec = make_rec(kot_pkg::REC_ERROR, kot_pkg::CLS_IDENT, char_ff, line_now,
                                  kot_pkg::ERR_FORBIDDEN);
               halt_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // The end of the text leaves the scanner idle with nothing held and no halt.
      if (cmd.end_text) begin
         mode_in = kot_pkg::MODE_IDLE;
         pcnt_in = '0;
         halt_in = 1'b0;
      end

      if (csr_wen) begin
         line_in = kot_pkg::line_load(csr_wdata);
      end
   end

   // One record waits in the hold stage until it is known whether it is the last of its item.
   always_comb begin
      hold_in     = hold_ff;
      hold_v_in   = hold_v_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      if (gen && hold_v_ff) begin
         out_in      = hold_ff;
         out_last_in = 1'b0;
         out_v_in    = 1'b1;
      end else if (cmd.flush_out && hold_v_ff && out_free) begin
         out_in      = hold_ff;
         out_last_in = 1'b1;
         out_v_in    = 1'b1;
         hold_v_in   = 1'b0;
      end
      if (gen) begin
         hold_in   = gen_rec;
         hold_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      eot_ff      <= eot_in;
      pend_ff     <= pend_in;
      hold_ff     <= hold_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      if (reset) begin
         mode_ff   <= kot_pkg::MODE_IDLE;
         pcnt_ff   <= '0;
         line_ff   <= kot_pkg::line_load(kot_pkg::FIRST_LINE_RESET);
         start_ff  <= '0;
         halt_ff   <= 1'b0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pcnt_ff   <= pcnt_in;
         line_ff   <= line_in;
         start_ff  <= start_in;
         halt_ff   <= halt_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{PAD_BITS{1'b0}}, out_ff.line, out_ff.val, out_ff.cls};
   assign rsp_tuser  = {out_ff.ek, out_ff.kind};
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/kot_ctrl.sv =====
// Tokenizer controller: sequences the phases of one input item over the datapath.
`default_nettype none
module kot_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire kot_pkg::status_type status,
   output kot_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_MAIN,
      ST_FLUSH,
      ST_CLOSE,
      ST_START
   } state_type;

   state_type                    state_ff, state_in;
   logic [kot_pkg::IDX_BITS-1:0] idx_ff, idx_in;
   logic                         tail_ff, tail_in;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      tail_in       = tail_ff;
      req_tready    = 1'b0;
      cmd.op        = kot_pkg::OP_NONE;
      cmd.idx       = idx_ff[kot_pkg::PEND_IDX_BITS-1:0];
      cmd.flush_out = 1'b0;
      cmd.end_text  = 1'b0;

      case (state_ff)
         ST_WAIT: begin
            cmd.flush_out = 1'b1;
            req_tready    = status.emit_ok;
            if (req_tvalid && status.emit_ok) begin
               cmd.op   = kot_pkg::OP_LATCH;
               state_in = ST_MAIN;
            end
         end
         ST_MAIN: begin
            if (status.emit_ok) begin
               idx_in = '0;
               if (status.halt) begin
                  cmd.end_text = status.eot;
                  state_in     = ST_WAIT;
               end else begin
                  // Next phase when the character stays in the current run.
                  state_in = status.eot ? ST_CLOSE : ST_WAIT;
                  tail_in  = 1'b1;
                  case (status.mode)
                     kot_pkg::MODE_STR: begin
                        cmd.op = kot_pkg::OP_STR_STEP;
                     end
                     kot_pkg::MODE_COMMENT: begin
                        if (status.newline) begin
                           cmd.op = kot_pkg::OP_START;
                        end
                     end
                     kot_pkg::MODE_ALPHA: begin
                        if (status.alnum) begin
                           if (status.pend_count <
                               kot_pkg::CNT_BITS'(kot_pkg::PEND_DEPTH)) begin
                              cmd.op = kot_pkg::OP_STORE;
                           end else begin
                              state_in = ST_FLUSH;
                           end
                        end else begin
                           state_in = ST_CLOSE;
                           tail_in  = 1'b0;
                        end
                     end
                     kot_pkg::MODE_IDENT: begin
                        if (status.alnum) begin
                           cmd.op = kot_pkg::OP_EMIT_CHAR;
                        end else begin
                           state_in = ST_CLOSE;
                           tail_in  = 1'b0;
                        end
                     end
                     kot_pkg::MODE_NUM: begin
                        if (status.num_char) begin
                           cmd.op = kot_pkg::OP_EMIT_CHAR;
                        end else begin
                           state_in = ST_CLOSE;
                           tail_in  = 1'b0;
                        end
                     end
                     kot_pkg::MODE_OP: begin
                        if (status.op_char) begin
                           cmd.op = kot_pkg::OP_STORE;
                        end else begin
                           state_in = ST_CLOSE;
                           tail_in  = 1'b0;
                        end
                     end
                     default: begin
                        cmd.op = kot_pkg::OP_START;
                     end
                  endcase
               end
            end
         end
         ST_FLUSH: begin
            if (status.emit_ok) begin
               if (idx_ff == kot_pkg::IDX_BITS'(kot_pkg::PEND_DEPTH)) begin
                  cmd.op   = kot_pkg::OP_FLUSH_LAST;
                  idx_in   = '0;
                  tail_in  = 1'b1;
                  state_in = status.eot ? ST_CLOSE : ST_WAIT;
               end else begin
                  cmd.op = kot_pkg::OP_EMIT_PEND;
                  idx_in = idx_ff + kot_pkg::IDX_BITS'(1);
               end
            end
         end
         ST_CLOSE: begin
            if (status.emit_ok) begin
               if (tail_ff && status.halt) begin
                  cmd.end_text = 1'b1;
                  state_in     = ST_WAIT;
               end else begin
                  state_in = tail_ff ? ST_WAIT : ST_START;
                  cmd.end_text = tail_ff;
                  case (status.mode)
                     kot_pkg::MODE_ALPHA: begin
                        if (status.hit) begin
                           cmd.op = kot_pkg::OP_CLOSE_HIT;
                        end else if (idx_ff < status.pend_count) begin
                           // Not a keyword: the held characters go out first.
                           cmd.op       = kot_pkg::OP_EMIT_PEND;
                           cmd.end_text = 1'b0;
                           idx_in       = idx_ff + kot_pkg::IDX_BITS'(1);
                           state_in     = ST_CLOSE;
                        end else begin
                           cmd.op = kot_pkg::OP_CLOSE_END;
                        end
                     end
                     kot_pkg::MODE_IDENT, kot_pkg::MODE_NUM, kot_pkg::MODE_STR: begin
                        cmd.op = kot_pkg::OP_CLOSE_END;
                     end
                     kot_pkg::MODE_OP: begin
                        cmd.op = status.hit ? kot_pkg::OP_CLOSE_HIT : kot_pkg::OP_CLOSE_ERR;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_START: begin
            if (status.emit_ok) begin
               if (!status.halt) begin
                  cmd.op = kot_pkg::OP_START;
               end
               idx_in   = '0;
               tail_in  = 1'b1;
               state_in = status.eot ? ST_CLOSE : ST_WAIT;
            end
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
         idx_ff   <= '0;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         tail_ff  <= tail_in;
      end
   end

endmodule
`default_nettype wire
